// ===== src/vlpd_pkg.sv =====
// Shared types and constants for the varint length-prefixed deframer.
// Used by every module of the block; depends on nothing.
package vlpd_pkg;

  localparam int unsigned GroupBits      = 7;
  localparam int unsigned MaxPrefixBytes = 5;
  localparam int unsigned MaxLenWidth    = 31;
  localparam int unsigned AccumWidth     = 32;
  localparam int unsigned CountWidth     = 3;
  localparam int unsigned AddrWidth      = 3;

  localparam logic [7:0] GroupMask = 8'b0111_1111;
  localparam logic [7:0] MoreFlag  = 8'b1000_0000;

  // Register word index of max_frame_length on the configuration port
  localparam logic REG_MAX_FRAME_LENGTH = 1'b0;

  typedef enum logic [1:0] {
    PH_LENGTH  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_FAILED  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } result_t;

endpackage

// ===== src/vlpd_decoder.sv =====
// Framing state and per-item decode: length prefix, payload count, error latch.
// Depends on vlpd_pkg.
module vlpd_decoder (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 step,
  input  logic [7:0]                           rx_byte,
  input  logic [vlpd_pkg::MaxLenWidth-1:0]     max_frame_length,
  output logic                                 res_valid,
  output vlpd_pkg::result_t                    res
);

  vlpd_pkg::phase_t                         phase, phase_next;
  logic [vlpd_pkg::AccumWidth-1:0]          length_accum, length_accum_next;
  logic [vlpd_pkg::CountWidth-1:0]          length_byte_count, length_byte_count_next;
  logic [vlpd_pkg::MaxLenWidth-1:0]         remaining, remaining_next;

  logic [6:0]                               grp;
  logic [vlpd_pkg::AccumWidth-1:0]          grp_shifted;
  logic [vlpd_pkg::AccumWidth-1:0]          len;
  logic                                     is_last;

  function automatic logic [vlpd_pkg::CountWidth-1:0] CountWidthMax();
    return vlpd_pkg::CountWidth'(vlpd_pkg::MaxPrefixBytes);
  endfunction

  assign grp = 7'(rx_byte & vlpd_pkg::GroupMask);

  // Place the 7-bit group at its position; the fifth group keeps 4 bits only
  always_comb begin
    case (length_byte_count)
      3'd0:    grp_shifted = {25'b0, grp};
      3'd1:    grp_shifted = {18'b0, grp, 7'b0};
      3'd2:    grp_shifted = {11'b0, grp, 14'b0};
      3'd3:    grp_shifted = {4'b0, grp, 21'b0};
      3'd4:    grp_shifted = {grp[3:0], 28'b0};
      default: grp_shifted = '0;
    endcase
  end

  assign len     = length_accum | grp_shifted;
  assign is_last = (remaining <= 31'd1);

  always_comb begin
    phase_next             = phase;
    length_accum_next      = length_accum;
    length_byte_count_next = length_byte_count;
    remaining_next         = remaining;
    res_valid              = 1'b0;
    res.kind               = vlpd_pkg::KIND_BYTE;
    res.data               = 8'd0;
    res.last               = 1'b0;
    if (step) begin
      case (phase)
        vlpd_pkg::PH_PAYLOAD: begin
          res_valid = 1'b1;
          res.data  = rx_byte;
          res.last  = is_last;
          if (is_last) begin
            remaining_next = '0;
            phase_next     = vlpd_pkg::PH_LENGTH;
          end else begin
            remaining_next = remaining - 31'd1;
          end
        end
        vlpd_pkg::PH_LENGTH: begin
          if (length_byte_count >= CountWidthMax()) begin
            // sixth prefix byte
            res_valid  = 1'b1;
            res.kind   = vlpd_pkg::KIND_ERROR;
            phase_next = vlpd_pkg::PH_FAILED;
          end else if ((rx_byte & vlpd_pkg::MoreFlag) != 8'd0) begin
            length_accum_next      = len;
            length_byte_count_next = length_byte_count + 3'd1;
          end else begin
            length_accum_next      = '0;
            length_byte_count_next = '0;
            if (len[31] || (len[30:0] > max_frame_length)) begin
              res_valid  = 1'b1;
              res.kind   = vlpd_pkg::KIND_ERROR;
              phase_next = vlpd_pkg::PH_FAILED;
            end else if (len == 32'd0) begin
              res_valid = 1'b1;
              res.kind  = vlpd_pkg::KIND_EMPTY;
              res.last  = 1'b1;
            end else begin
              remaining_next = len[30:0];
              phase_next     = vlpd_pkg::PH_PAYLOAD;
            end
          end
        end
        default: begin
          // failed: drop everything until reset
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= vlpd_pkg::PH_LENGTH;
      length_accum      <= '0;
      length_byte_count <= '0;
      remaining         <= '0;
    end else begin
      phase             <= phase_next;
      length_accum      <= length_accum_next;
      length_byte_count <= length_byte_count_next;
      remaining         <= remaining_next;
    end
  end

  a_failed_sticks: assert property (@(posedge clk) disable iff (rst)
    phase == vlpd_pkg::PH_FAILED |=> phase == vlpd_pkg::PH_FAILED)
    else $error("failed state left without reset");

  a_error_fails: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == vlpd_pkg::KIND_ERROR |=> phase == vlpd_pkg::PH_FAILED)
    else $error("error result without entering failed state");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    length_byte_count <= 3'd5)
    else $error("length byte count out of range");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == vlpd_pkg::PH_PAYLOAD |-> remaining != '0)
    else $error("payload phase with nothing remaining");

endmodule

// ===== src/vlpd_out_fifo.sv =====
// Two-entry result queue that decouples the decoder from downstream backpressure.
// Depends on vlpd_pkg.
module vlpd_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  vlpd_pkg::result_t push_data,
  output logic              space,
  output logic              pop_valid,
  input  logic              pop_ready,
  output vlpd_pkg::result_t pop_data
);

  vlpd_pkg::result_t mem [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (count != 2'd0);
  assign pop_data  = mem[rd_ptr];
  // Registered-only, so upstream ready never waits on downstream ready
  assign space     = (count != 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> space)
    else $error("push into full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("queue count out of range");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> wr_ptr == rd_ptr)
    else $error("queue pointers disagree with count");

endmodule

// ===== src/varint_length_prefixed_deframer_core.sv =====
// An accepted item is held in the input register; any result is queued for the master side.
// Throughput: one item per cycle; the input register and decoder advance whenever the two-entry
// result queue has room, so a full queue (downstream stalled two items) is what holds input.
// Prefix bytes give a result only for an empty frame or an error; items after an error give none.
// Reset (rst, synchronous, active high): decoder back to reading a length, queue and input
// register emptied, max_frame_length restored to 2147483647.
module varint_length_prefixed_deframer_core (
  input  logic                              clk,
  input  logic                              rst,
  // stream in
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [7:0] rx_byte
  // stream out
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [7:0]                        m_tdata,   // [7:0] data
  output logic [1:0]                        m_tuser,   // [1:0] kind
  output logic                              m_tlast,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [vlpd_pkg::AddrWidth-1:0]    paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  // Configuration register
  logic [vlpd_pkg::MaxLenWidth-1:0] max_frame_length;
  logic                             reg_sel;

  // Input register
  logic       in_valid;
  logic [7:0] in_byte;

  // Decode step and result queue
  logic              step;
  logic              space;
  logic              res_valid;
  vlpd_pkg::result_t res;
  vlpd_pkg::result_t out_res;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == vlpd_pkg::REG_MAX_FRAME_LENGTH);
  assign prdata  = reg_sel ? {1'b0, max_frame_length} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_length <= '1;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      // drop bit 31 of the written value
      max_frame_length <= pwdata[30:0];
    end
  end

  // Advance the held byte through the decoder whenever the queue can take a result
  assign step     = in_valid && space;
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // Payload only; captured on every accept
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  vlpd_decoder u_decoder (
    .clk              (clk),
    .rst              (rst),
    .step             (step),
    .rx_byte          (in_byte),
    .max_frame_length (max_frame_length),
    .res_valid        (res_valid),
    .res              (res)
  );

  vlpd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .space     (space),
    .pop_valid (m_tvalid),
    .pop_ready (m_tready),
    .pop_data  (out_res)
  );

  assign m_tdata = out_res.data;
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last;

  a_step_has_room: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> step)
    else $error("result produced without a decode step");

  a_hold_when_full: assert property (@(posedge clk) disable iff (rst)
    in_valid && !space |=> in_valid && $stable(in_byte))
    else $error("held input item lost while queue full");

  a_result_kind_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != vlpd_pkg::KIND_BYTE |-> m_tdata == 8'd0)
    else $error("nonzero data on a non-payload result");

endmodule
